[hdl/fbc128_pkg.sv]
// Shared types, constants and round-function helpers of the 128-bit Feistel cipher.
`default_nettype none
package fbc128_pkg;

    localparam int ROUNDS        = 48;
    localparam int MAX_KEY_WORDS = 4;
    localparam int RW            = $clog2(ROUNDS);
    localparam int KCW           = 3;

    localparam logic [63:0] WHITE_L_K   = 64'h517CC1B727220A95;
    localparam logic [63:0] WHITE_R_K   = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SCHED_XOR_K = 64'h6A09E667F3BCC908;
    localparam logic [7:0]  GF_POLY     = 8'h1B;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_COUNT = 3'd4;

    // Steps inside one round.
    localparam logic [2:0] PH_Q0  = 3'd0;
    localparam logic [2:0] PH_Q1  = 3'd1;
    localparam logic [2:0] PH_Q2  = 3'd2;
    localparam logic [2:0] PH_Q3  = 3'd3;
    localparam logic [2:0] PH_MIX = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic        req_type;
        logic        first_block;
        logic [63:0] block_low;
        logic [63:0] block_high;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [63:0] value;
    } t_cfg_item;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    // Left rotation by an amount that is a constant at each call site.
    function automatic logic [63:0] rotl(input logic [63:0] v, input int n);
        logic [63:0] r;
        r = v;
        if (n % 64 != 0) begin
            r = (v << (n % 64)) | (v >> (64 - (n % 64)));
        end
        return r;
    endfunction

    function automatic logic [7:0] gf_dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    // One ARX quarter round; q picks the fixed rotation amounts.
    function automatic logic [63:0] quarter(input logic [63:0] h, input logic [63:0] qc,
                                            input logic [63:0] k, input logic [1:0] q);
        logic [63:0] v;
        v = h + qc;
        case (q)
            2'd0:    v = rotl(rotl(v, 7) ^ k, 13);
            2'd1:    v = rotl(rotl(v, 8) ^ k, 14);
            2'd2:    v = rotl(rotl(v, 9) ^ k, 15);
            default: v = rotl(rotl(v, 10) ^ k, 16);
        endcase
        v = v + k;
        case (q)
            2'd0:    v = rotl(v, 17);
            2'd1:    v = rotl(v, 18);
            2'd2:    v = rotl(v, 19);
            default: v = rotl(v, 20);
        endcase
        return v;
    endfunction

    // Byte substitution, column mixing, row shuffle and key injection.
    function automatic logic [63:0] mix_final(input logic [63:0] h0, input logic [63:0] h1,
                                              input logic [63:0] k);
        logic [7:0]   b [16];
        logic [7:0]   m [16];
        logic [7:0]   s [16];
        logic [127:0] hw;
        logic [127:0] ow;
        hw = {h1, h0};
        for (int i = 0; i < 16; i++) begin
            b[i] = SBOX[hw[i*8 +: 8]];
        end
        for (int c = 0; c < 16; c += 4) begin
            m[c]   = gf_dbl(b[c]) ^ gf_dbl(b[c+1]) ^ b[c+1] ^ b[c+2] ^ b[c+3];
            m[c+1] = b[c] ^ gf_dbl(b[c+1]) ^ gf_dbl(b[c+2]) ^ b[c+2] ^ b[c+3];
            m[c+2] = b[c] ^ b[c+1] ^ gf_dbl(b[c+2]) ^ gf_dbl(b[c+3]) ^ b[c+3];
            m[c+3] = gf_dbl(b[c]) ^ b[c] ^ b[c+1] ^ b[c+2] ^ gf_dbl(b[c+3]);
        end
        s = m;
        s[1]  = m[5];  s[5]  = m[9];  s[9]  = m[13]; s[13] = m[1];
        s[2]  = m[10]; s[10] = m[2];
        s[6]  = m[14]; s[14] = m[6];
        s[3]  = m[15]; s[15] = m[11]; s[11] = m[7];  s[7]  = m[3];
        for (int i = 0; i < 16; i++) begin
            ow[i*8 +: 8] = s[i];
        end
        return (ow[63:0] ^ k) ^ (ow[127:64] + k);
    endfunction

endpackage
`default_nettype wire

[hdl/fbc128_if.sv]
// Valid/ready channel interfaces for blocks, results and configuration writes.
`default_nettype none
interface fbc128_in_if;
    logic                valid;
    logic                ready;
    fbc128_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fbc128_out_if;
    logic                 valid;
    logic                 ready;
    fbc128_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fbc128_cfg_if;
    logic                 valid;
    logic                 ready;
    fbc128_pkg::t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/feistel_block_cipher_128_top.sv]
// Top level of the 128-bit Feistel block cipher: key schedule and shared round unit.
//
//  Channel  Direction  Payload                                     Transfer when
//  i_in     in         req_type, first_block, block_low/high       valid & ready
//  o_out    out        result_low, result_high                     valid & ready
//  i_cfg    in         index (0..4 used), value                    valid & ready
//
// Each round has four quarter-round steps and one substitution and mixing step, all on
// one shared round unit, into which a block is loaded when it is taken.
// A register write starts a key expansion of ROUNDS round keys (one round key per cycle).
// Reset clears control, whitening sums and previous plaintext; round keys are undefined
// until the first register write. A result waits in the output register; the next
// block is taken meanwhile, and its last round holds until that register is free.
`default_nettype none
module feistel_block_cipher_128_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    fbc128_in_if.sink           i_in,
    fbc128_out_if.source        o_out,
    fbc128_cfg_if.sink          i_cfg
);

    localparam int RW = fbc128_pkg::RW;

    fbc128_pkg::t_state r_state, n_state;

    logic [63:0]   r_kw [4];
    logic [63:0]   r_rw [4];
    logic [2:0]    r_kcnt;
    logic [RW-1:0] r_er;
    logic [63:0]   r_prevk;
    logic [63:0]   r_ml, r_mr;
    logic [63:0]   r_qc [4];

    logic [63:0]   r_rkmem [fbc128_pkg::ROUNDS];
    logic [63:0]   r_rk;

    logic [63:0]   r_a, r_c, r_h0, r_h1;
    logic [2:0]    r_phase;
    logic [RW-1:0] r_ri;
    logic          r_dec;
    logic [63:0]   r_wl, r_wr, r_pl, r_ph;

    logic          r_ovalid;
    fbc128_pkg::t_out_item r_out;

    logic          in_ready, cfg_ready, in_xfer, cfg_xfer, cfg_hit;
    logic          rd_en;
    logic [RW-1:0] rd_addr;
    logic          last_round, finish, exp_done;
    logic [63:0]   n_kw [4];
    logic [2:0]    n_kcnt, kcnt_sat;
    logic [63:0]   rk_raw, rk_new;
    logic [63:0]   f_out, n_a, n_c;
    logic [63:0]   wl_eff, wr_eff, pl_eff, ph_eff;

    assign in_xfer  = i_in.valid && in_ready;
    assign cfg_xfer = i_cfg.valid && cfg_ready;
    assign cfg_hit  = cfg_xfer && (i_cfg.data.index <= fbc128_pkg::REG_COUNT);

    assign last_round = r_dec ? (r_ri == '0) : (r_ri == RW'(fbc128_pkg::ROUNDS - 1));
    assign finish     = (r_state == fbc128_pkg::ST_ROUND) && (r_phase == fbc128_pkg::PH_MIX)
                        && last_round && (!r_ovalid || o_out.ready);
    assign exp_done   = (r_er == RW'(fbc128_pkg::ROUNDS - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fbc128_pkg::ST_IDLE: begin
                if (cfg_hit) begin
                    n_state = fbc128_pkg::ST_EXPAND;
                end else if (in_xfer) begin
                    n_state = fbc128_pkg::ST_ROUND;
                end
            end
            fbc128_pkg::ST_EXPAND: begin
                if (exp_done) begin
                    n_state = fbc128_pkg::ST_IDLE;
                end
            end
            fbc128_pkg::ST_ROUND: begin
                if (finish) begin
                    n_state = fbc128_pkg::ST_IDLE;
                end
            end
            default: n_state = fbc128_pkg::ST_IDLE;
        endcase
    end

    // Handshake and round-key read control.
    always_comb begin
        cfg_ready = 1'b0;
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        case (r_state)
            fbc128_pkg::ST_IDLE: begin
                cfg_ready = 1'b1;
                in_ready  = !i_cfg.valid;
                rd_en     = in_xfer;
                rd_addr   = i_in.data.req_type ? RW'(fbc128_pkg::ROUNDS - 1) : '0;
            end
            fbc128_pkg::ST_ROUND: begin
                rd_en   = (r_phase == fbc128_pkg::PH_MIX) && !last_round;
                rd_addr = r_dec ? (r_ri - 1'b1) : (r_ri + 1'b1);
            end
            default: begin
                cfg_ready = 1'b0;
            end
        endcase
    end

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = cfg_ready;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    // Register file update from the configuration port.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_kw[i] = r_kw[i];
            if (cfg_xfer && i_cfg.data.index == 3'(i)) begin
                n_kw[i] = i_cfg.data.value;
            end
        end
        n_kcnt = r_kcnt;
        if (cfg_xfer && i_cfg.data.index == fbc128_pkg::REG_COUNT) begin
            n_kcnt = i_cfg.data.value[2:0];
        end
    end

    // One key-schedule step: the word copies rotate by one bit per round.
    always_comb begin
        kcnt_sat = (r_kcnt > 3'(fbc128_pkg::MAX_KEY_WORDS)) ? 3'(fbc128_pkg::MAX_KEY_WORDS)
                                                             : r_kcnt;
        rk_raw = kcnt_sat[0] ? r_ml : 64'd0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < kcnt_sat) begin
                rk_raw = rk_raw ^ r_rw[i];
            end
        end
        rk_new = (r_er == '0) ? rk_raw
               : (fbc128_pkg::rotl(rk_raw + r_prevk, 31) ^ fbc128_pkg::SCHED_XOR_K);
    end

    // Feistel step of the current block and whitening values of the incoming block.
    always_comb begin
        f_out = fbc128_pkg::mix_final(r_h0, r_h1, r_rk);
        if (r_dec) begin
            n_a = r_c ^ f_out;
            n_c = r_a;
        end else begin
            n_a = r_c;
            n_c = r_a ^ f_out;
        end
        wl_eff = i_in.data.first_block ? 64'd0 : r_wl;
        wr_eff = i_in.data.first_block ? 64'd0 : r_wr;
        pl_eff = i_in.data.first_block ? 64'd0 : r_pl;
        ph_eff = i_in.data.first_block ? 64'd0 : r_ph;
    end

    // Round-key memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == fbc128_pkg::ST_EXPAND) begin
            r_rkmem[r_er] <= rk_new;
        end
        if (rd_en) begin
            r_rk <= r_rkmem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fbc128_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_phase  <= fbc128_pkg::PH_Q0;
            r_er     <= '0;
            r_kcnt   <= 3'd2;
            for (int i = 0; i < 4; i++) begin
                r_kw[i] <= 64'd0;
            end
        end else begin
            r_state <= n_state;
            r_kcnt  <= n_kcnt;
            r_kw    <= n_kw;
            if (finish) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_hit) begin
                r_er <= '0;
            end else if (r_state == fbc128_pkg::ST_EXPAND) begin
                r_er <= r_er + 1'b1;
            end
            if (in_xfer) begin
                r_phase <= fbc128_pkg::PH_Q0;
            end else if (r_state == fbc128_pkg::ST_ROUND) begin
                if (r_phase == fbc128_pkg::PH_MIX) begin
                    if (!last_round) begin
                        r_phase <= fbc128_pkg::PH_Q0;
                    end
                end else begin
                    r_phase <= r_phase + 1'b1;
                end
            end
        end
    end

    // Chaining state: whitening sums and previous plaintext.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl <= 64'd0;
            r_wr <= 64'd0;
            r_pl <= 64'd0;
            r_ph <= 64'd0;
        end else begin
            if (in_xfer) begin
                r_wl <= wl_eff;
                r_wr <= wr_eff;
                r_pl <= i_in.data.req_type ? pl_eff : i_in.data.block_low;
                r_ph <= i_in.data.req_type ? ph_eff : i_in.data.block_high;
            end else if (finish) begin
                r_wl <= r_wl + fbc128_pkg::WHITE_L_K;
                r_wr <= r_wr + fbc128_pkg::WHITE_R_K;
                if (r_dec) begin
                    r_pl <= n_a ^ r_wl ^ r_pl;
                    r_ph <= n_c ^ r_wr ^ r_ph;
                end
            end
        end
    end

    // Key schedule datapath.
    always_ff @(posedge i_clk) begin
        if (cfg_hit) begin
            r_rw  <= n_kw;
            r_ml  <= 64'd0;
            r_mr  <= 64'd0;
        end else if (r_state == fbc128_pkg::ST_EXPAND) begin
            for (int i = 0; i < 4; i++) begin
                r_rw[i] <= fbc128_pkg::rotl(r_rw[i], 1);
            end
            r_ml    <= r_ml + fbc128_pkg::WHITE_L_K;
            r_mr    <= r_mr + fbc128_pkg::WHITE_R_K;
            r_prevk <= rk_new;
            if (r_er < RW'(4)) begin
                r_qc[r_er[1:0]] <= rk_new ^ r_mr;
            end
        end
    end

    // Shared round unit.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_dec <= i_in.data.req_type;
            r_ri  <= i_in.data.req_type ? RW'(fbc128_pkg::ROUNDS - 1) : '0;
            if (i_in.data.req_type) begin
                r_a <= i_in.data.block_low;
                r_c <= i_in.data.block_high;
            end else begin
                r_a <= i_in.data.block_low ^ wl_eff ^ pl_eff;
                r_c <= i_in.data.block_high ^ wr_eff ^ ph_eff;
            end
        end else if (r_state == fbc128_pkg::ST_ROUND) begin
            case (r_phase)
                fbc128_pkg::PH_Q0: begin
                    r_h0 <= fbc128_pkg::quarter(r_dec ? r_a : r_c, r_qc[0], r_rk, 2'd0);
                    r_h1 <= r_rk;
                end
                fbc128_pkg::PH_Q1: r_h1 <= fbc128_pkg::quarter(r_h1, r_qc[1], r_rk, 2'd1);
                fbc128_pkg::PH_Q2: r_h0 <= fbc128_pkg::quarter(r_h0, r_qc[2], r_rk, 2'd2);
                fbc128_pkg::PH_Q3: r_h1 <= fbc128_pkg::quarter(r_h1, r_qc[3], r_rk, 2'd3);
                fbc128_pkg::PH_MIX: begin
                    if (!last_round) begin
                        r_a  <= n_a;
                        r_c  <= n_c;
                        r_ri <= r_dec ? (r_ri - 1'b1) : (r_ri + 1'b1);
                    end else if (finish) begin
                        if (r_dec) begin
                            r_out.result_low  <= n_a ^ r_wl ^ r_pl;
                            r_out.result_high <= n_c ^ r_wr ^ r_ph;
                        end else begin
                            r_out.result_low  <= n_a;
                            r_out.result_high <= n_c;
                        end
                    end
                end
                default: r_h0 <= r_h0;
            endcase
        end
    end

    // A result appears only after the last mixing step of a block.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == fbc128_pkg::ST_ROUND)
                            && $past(r_phase == fbc128_pkg::PH_MIX))
        else $error("result without a finished block");

    // Key expansion never runs past the last round key.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbc128_pkg::ST_EXPAND) |=> (r_er != '0) || (r_state != fbc128_pkg::ST_EXPAND))
        else $error("key expansion index wrapped");

    // A configuration write and a block transfer never land in the same cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_xfer |-> !in_xfer)
        else $error("configuration and block transfer collide");

    // The round phase stays within its defined steps.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbc128_pkg::ST_ROUND) |-> (r_phase <= fbc128_pkg::PH_MIX))
        else $error("round phase out of range");

endmodule
`default_nettype wire
